/* design/bfvt_pkg.sv */
// ----------------------------------------------------------------------------
// bfvt_pkg
// Shared widths, constants, codes and types of the breath flow volume tracker.
// ----------------------------------------------------------------------------
package bfvt_pkg;

    localparam int ACC_WIDTH  = 40;
    localparam int FLOW_WIDTH = 15;

    localparam int TIME_W  = 32;
    localparam int THR_W   = 10;
    localparam int PVOL_W  = 24;
    localparam int RATE_W  = 16;
    localparam int PROD_W  = FLOW_WIDTH + TIME_W + 1;
    localparam int SUM_W   = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

    // volume in 1/64 mL is flow*ms / 60; rate in 1/16 bpm is 60*1000*16 / ms
    localparam int unsigned VOL_DIV  = 60;
    localparam int unsigned RATE_NUM = 60 * 1000 * 16;

    // any |acc| at or above this saturates the 24-bit phase volume
    localparam logic [63:0] VOL_SAT = 64'(VOL_DIV) << PVOL_W;

    // x / 60 = (x >> 2) / 15 for x below 2^30; 15 * 0x11111112 = 2^32 + 14
    localparam int VIN_W   = 28;
    localparam int VREC_W  = 29;
    localparam int VPROD_W = VIN_W + VREC_W;
    localparam int VSHIFT  = 32;
    localparam logic [VREC_W-1:0] VOL_RECIP = VREC_W'(32'h1111_1112);

    localparam int DIV_DW = 20;
    localparam int DIV_CW = $clog2(DIV_DW);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(32);

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam logic [CFG_AW-3:0] REG_THRESHOLD = '0;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_INSP_END = 2'd1,
        EV_EXP_END  = 2'd2
    } t_phase_event;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } t_div_rsp;

endpackage

/* design/bfvt_if.sv */
// ----------------------------------------------------------------------------
// bfvt_in_if / bfvt_out_if
// Valid/ready channels carrying flow samples in and phase results out.
// ----------------------------------------------------------------------------
interface bfvt_in_if;
    import bfvt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [FLOW_WIDTH-1:0] flow_sample;
    logic [TIME_W-1:0]            sample_time_ms;
    logic                         resync;

    modport source (output valid, flow_sample, sample_time_ms, resync, input ready);
    modport sink   (input valid, flow_sample, sample_time_ms, resync, output ready);
endinterface

interface bfvt_out_if;
    import bfvt_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [FLOW_WIDTH-1:0] flow_echo;
    t_phase_event                 phase_event;
    logic signed [PVOL_W-1:0]     phase_volume;
    logic [RATE_W-1:0]            breath_rate;

    modport source (output valid, flow_echo, phase_event, phase_volume, breath_rate,
                    input ready);
    modport sink   (input valid, flow_echo, phase_event, phase_volume, breath_rate,
                    output ready);
endinterface

/* design/breath_flow_volume_tracker.sv */
// ----------------------------------------------------------------------------
// breath_flow_volume_tracker
// Integrates flow over time per breath phase, reports phase volume at each
// change of direction and respiratory rate at each end of inspiration.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  i_in      | in  | valid/ready            | flow_sample, sample_time_ms, resync
//  o_out     | out | valid/ready            | flow_echo, phase_event,
//            |     |                        | phase_volume, breath_rate
//  apb       | in  | psel/penable/pwrite    | paddr, pwdata, prdata (threshold)
//
//  A setup sample returns to idle after evaluation; a sample without direction
//  change goes through the multiply, accumulate and emit states. An expiration
//  end adds the reciprocal multiply and clamp of the volume; an inspiration end
//  adds the 20-step rate divider as well. Reset is synchronous; the block starts
//  in setup with the threshold at 32. The output register decouples the sides:
//  a new sample is taken while a result waits, and the sequencer stalls only to
//  hand over the next result.
// ----------------------------------------------------------------------------
module breath_flow_volume_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfvt_in_if.sink                       i_in,
    bfvt_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfvt_pkg::CFG_AW-1:0]   paddr,
    input  logic [bfvt_pkg::CFG_DW-1:0]   pwdata,
    output logic [bfvt_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);
    import bfvt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_VDIV,
        S_VFIX,
        S_RDIV,
        S_MUL,
        S_ACC,
        S_EMIT
    } t_state;

    localparam logic signed [SUM_W-1:0] SUM_MAX =
        SUM_W'({1'b0, {(ACC_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);

    t_state                       r_state;
    logic signed [FLOW_WIDTH-1:0] r_flow;
    logic [TIME_W-1:0]            r_time;
    logic                         r_resync;
    logic signed [ACC_WIDTH-1:0]  r_acc;
    logic [TIME_W-1:0]            r_prev_time;
    logic [TIME_W-1:0]            r_last_insp;
    logic                         r_prev_pos;
    logic                         r_in_setup;
    logic [1:0]                   r_changes_seen;
    t_phase_event                 r_event;
    logic                         r_vneg;
    logic [PVOL_W-1:0]            r_vq;
    logic [TIME_W-1:0]            r_rd;
    logic [TIME_W-1:0]            r_dt;
    logic signed [PVOL_W-1:0]     r_pvol;
    logic [RATE_W-1:0]            r_rate;
    logic signed [PROD_W-1:0]     r_prod;
    logic                         r_out_valid;
    logic signed [FLOW_WIDTH-1:0] r_out_flow;
    t_phase_event                 r_out_event;
    logic signed [PVOL_W-1:0]     r_out_pvol;
    logic [RATE_W-1:0]            r_out_rate;

    logic [THR_W-1:0]             thr;
    logic                         pos;
    logic                         change;
    logic                         setup_now;
    logic [1:0]                   cnt_base;
    logic [1:0]                   cnt_inc;
    logic [ACC_WIDTH-1:0]         acc_abs;
    logic                         vol_sat;
    logic [VPROD_W-1:0]           vprod;
    logic [PVOL_W-1:0]            vol_q;
    logic signed [PVOL_W-1:0]     pvol_val;
    logic [RATE_W-1:0]            rate_val;
    logic signed [PROD_W-1:0]     mul;
    logic signed [ACC_WIDTH-1:0]  acc_base;
    logic signed [SUM_W-1:0]      sum;
    logic signed [ACC_WIDTH-1:0]  acc_next;
    logic                         out_load;
    t_div_req                     div_req;
    t_div_rsp                     div_rsp;

    bfvt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (thr)
    );

    bfvt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign pos = $signed({r_flow[FLOW_WIDTH-1], r_flow}) >=
                 $signed({{(FLOW_WIDTH+1-THR_W){1'b0}}, thr});
    assign change    = (pos != r_prev_pos);
    assign setup_now = r_in_setup || r_resync;
    assign cnt_base  = r_resync ? 2'd0 : r_changes_seen;
    assign cnt_inc   = cnt_base + 2'd1;

    assign acc_abs = r_acc[ACC_WIDTH-1] ? (~r_acc + 1'b1) : r_acc;
    assign vol_sat = (64'(acc_abs) >= VOL_SAT);
    assign vprod   = acc_abs[VIN_W+1:2] * VOL_RECIP;
    assign vol_q   = vol_sat ? '1 : vprod[VSHIFT+PVOL_W-1:VSHIFT];

    always_comb begin
        if (r_vneg) begin
            pvol_val = r_vq[PVOL_W-1] ? {1'b1, {(PVOL_W-1){1'b0}}} : (~r_vq + 1'b1);
        end else begin
            pvol_val = r_vq[PVOL_W-1] ? {1'b0, {(PVOL_W-1){1'b1}}} : r_vq;
        end
    end

    assign rate_val = (|div_rsp.quotient[DIV_DW-1:RATE_W]) ? '1
                                                            : div_rsp.quotient[RATE_W-1:0];

    assign mul      = $signed(r_flow) * $signed({1'b0, r_dt});
    assign acc_base = (r_event != EV_NONE) ? '0 : r_acc;
    assign sum      = SUM_W'(acc_base) + SUM_W'(r_prod);

    always_comb begin
        if (sum > SUM_MAX) begin
            acc_next = SUM_MAX[ACC_WIDTH-1:0];
        end else if (sum < SUM_MIN) begin
            acc_next = SUM_MIN[ACC_WIDTH-1:0];
        end else begin
            acc_next = sum[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        div_req.start    = (r_state == S_VFIX) && (r_event == EV_INSP_END);
        div_req.dividend = DIV_DW'(RATE_NUM);
        div_req.divisor  = r_rd;
    end

    assign out_load = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_acc          <= '0;
            r_prev_time    <= '0;
            r_last_insp    <= '0;
            r_prev_pos     <= 1'b1;
            r_in_setup     <= 1'b1;
            r_changes_seen <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_flow   <= i_in.flow_sample;
                        r_time   <= i_in.sample_time_ms;
                        r_resync <= i_in.resync;
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (setup_now) begin
                        if (change) begin
                            if (r_prev_pos) begin
                                r_last_insp <= r_time;
                            end
                            r_prev_pos <= pos;
                            if (cnt_inc == 2'd2) begin
                                r_in_setup     <= 1'b0;
                                r_changes_seen <= '0;
                                r_prev_time    <= r_time;
                                r_acc          <= '0;
                            end else begin
                                r_in_setup     <= 1'b1;
                                r_changes_seen <= cnt_inc;
                            end
                        end else begin
                            r_in_setup     <= 1'b1;
                            r_changes_seen <= cnt_base;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_dt        <= r_time - r_prev_time;
                        r_prev_time <= r_time;
                        r_pvol      <= '0;
                        r_rate      <= '0;
                        r_rd        <= r_time - r_last_insp;
                        r_vneg      <= r_acc[ACC_WIDTH-1] ^ !r_prev_pos;
                        if (change) begin
                            r_event    <= r_prev_pos ? EV_INSP_END : EV_EXP_END;
                            r_prev_pos <= pos;
                            if (r_prev_pos) begin
                                r_last_insp <= r_time;
                            end
                            r_state <= S_VDIV;
                        end else begin
                            r_event <= EV_NONE;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_VDIV: begin
                    r_vq    <= vol_q;
                    r_state <= S_VFIX;
                end
                S_VFIX: begin
                    r_pvol  <= pvol_val;
                    r_state <= (r_event == EV_INSP_END) ? S_RDIV : S_MUL;
                end
                S_RDIV: begin
                    if (div_rsp.done) begin
                        r_rate  <= rate_val;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= mul;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc   <= acc_next;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out_flow  <= r_flow;
                        r_out_event <= r_event;
                        r_out_pvol  <= r_pvol;
                        r_out_rate  <= r_rate;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.flow_echo    = r_out_flow;
    assign o_out.phase_event  = r_out_event;
    assign o_out.phase_volume = r_out_pvol;
    assign o_out.breath_rate  = r_out_rate;

    a_none_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.phase_event == EV_NONE) |->
            (o_out.phase_volume == '0 && o_out.breath_rate == '0))
        else $error("result without phase end carries volume or rate");

    a_exp_no_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.phase_event == EV_EXP_END) |-> (o_out.breath_rate == '0))
        else $error("expiration end carries a rate");

    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT || r_state == S_MUL) |-> !div_rsp.busy)
        else $error("divider busy outside division states");

    a_setup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_changes_seen == 2'd0 || r_changes_seen == 2'd1))
        else $error("setup change count out of range");

    a_setup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && setup_now) |=> (r_state == S_IDLE && !$rose(r_out_valid)))
        else $error("setup sample produced a result");

endmodule

/* design/bfvt_cfg.sv */
// ----------------------------------------------------------------------------
// bfvt_cfg
// APB register holding the direction threshold.
// ----------------------------------------------------------------------------
module bfvt_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfvt_pkg::CFG_AW-1:0]   paddr,
    input  logic [bfvt_pkg::CFG_DW-1:0]   pwdata,
    output logic [bfvt_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output logic [bfvt_pkg::THR_W-1:0]    o_threshold
);
    import bfvt_pkg::*;

    logic [THR_W-1:0] r_thr;
    logic             hit;

    assign hit = (paddr[CFG_AW-1:2] == REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready      = 1'b1;
    assign prdata      = hit ? CFG_DW'(r_thr) : '0;
    assign o_threshold = r_thr;

endmodule

/* design/bfvt_div.sv */
// ----------------------------------------------------------------------------
// bfvt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfvt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfvt_pkg::t_div_req i_req,
    output bfvt_pkg::t_div_rsp o_rsp
);
    import bfvt_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [TIME_W-1:0] r_rem;
    logic [DIV_DW-1:0] r_quo;
    logic [TIME_W-1:0] r_dsr;

    logic [TIME_W:0]   rem_sh;
    logic [TIME_W+1:0] diff;
    logic              qbit;

    assign rem_sh = {r_rem, r_quo[DIV_DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dsr};
    assign qbit   = !diff[TIME_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_DW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], qbit};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the breath flow volume tracker. Flow samples go in
// over a valid/ready channel with random gaps while the result channel stalls
// at random. Each accepted sample is run through a local model of the phase
// tracker: setup wait, direction changes, saturating volume integration and
// the rate divide. The results it gives are checked field by field against
// the block's output. The threshold register is rewritten over APB between
// phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_top;
    import bfvt_pkg::*;

    localparam int    SETTLE_CYCLES   = 100;
    localparam int    ITEMS_PER_PHASE = 200;
    localparam int    RAND_PHASES     = 5;
    localparam longint ACC_MAX        = (longint'(1) << (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN        = -ACC_MAX - 1;
    localparam longint PVOL_MAX       = (longint'(1) << (PVOL_W - 1)) - 1;
    localparam longint PVOL_MIN       = -PVOL_MAX - 1;
    localparam int    FLOW_MAX        = (1 << (FLOW_WIDTH - 1)) - 1;
    localparam int    FLOW_MIN        = -FLOW_MAX - 1;

    typedef struct packed {
        logic signed [FLOW_WIDTH-1:0] flow;
        logic [TIME_W-1:0]            t_ms;
        logic                         resync;
    } t_flow_sample;

    typedef struct packed {
        logic signed [FLOW_WIDTH-1:0] flow;
        t_phase_event                 ev;
        logic signed [PVOL_W-1:0]     vol;
        logic [RATE_W-1:0]            rate;
    } t_phase_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    bfvt_in_if  in_if ();
    bfvt_out_if out_if ();

    breath_flow_volume_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_flow_sample  sample_backlog[$];
    t_phase_report phase_reports[$];

    int n_queued      = 0;
    int n_accepted    = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int send_gap_pct  = 21;
    int recv_stall_pct = 48;

    // tracker state
    logic [THR_W-1:0]  thr_cfg        = THR_RESET;
    longint            vol_acc        = 0;
    logic [TIME_W-1:0] prev_t_ms      = '0;
    logic [TIME_W-1:0] last_insp_end  = '0;
    bit                prev_insp      = 1'b1;
    bit                in_setup       = 1'b1;
    int                changes_seen   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at result %0d: %s", n_results, what);
        n_errors++;
    endtask

    function automatic void integrate_sample(input t_flow_sample s);
        t_phase_report     rep;
        longint            flow_v;
        longint            vol;
        longint            prod;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] rd;
        bit                insp;
        flow_v = longint'(s.flow);
        insp   = flow_v >= longint'(thr_cfg);
        if (s.resync) begin
            in_setup     = 1'b1;
            changes_seen = 0;
        end
        if (in_setup) begin
            if (insp != prev_insp) begin
                if (prev_insp) begin
                    last_insp_end = s.t_ms;
                end
                prev_insp = insp;
                changes_seen++;
                if (changes_seen >= 2) begin
                    in_setup     = 1'b0;
                    changes_seen = 0;
                    prev_t_ms    = s.t_ms;
                    vol_acc      = 0;
                end
            end
            return;
        end
        rep.flow = s.flow;
        rep.ev   = EV_NONE;
        rep.vol  = '0;
        rep.rate = '0;
        if (insp != prev_insp) begin
            vol = vol_acc / longint'(VOL_DIV);
            if (prev_insp) begin
                rd     = s.t_ms - last_insp_end;
                rep.ev = EV_INSP_END;
                if (rd == 0 || RATE_NUM / rd > 65535) begin
                    rep.rate = '1;
                end else begin
                    rep.rate = RATE_W'(RATE_NUM / rd);
                end
                last_insp_end = s.t_ms;
            end else begin
                rep.ev = EV_EXP_END;
                vol    = -vol;
            end
            if (vol > PVOL_MAX) vol = PVOL_MAX;
            if (vol < PVOL_MIN) vol = PVOL_MIN;
            rep.vol   = vol[PVOL_W-1:0];
            prev_insp = insp;
            vol_acc   = 0;
        end
        dt        = s.t_ms - prev_t_ms;
        prev_t_ms = s.t_ms;
        prod      = flow_v * longint'(dt);
        if (prod > 0 && vol_acc > ACC_MAX - prod) begin
            vol_acc = ACC_MAX;
        end else if (prod < 0 && vol_acc < ACC_MIN - prod) begin
            vol_acc = ACC_MIN;
        end else begin
            vol_acc = vol_acc + prod;
        end
        phase_reports.push_back(rep);
    endfunction

    // drive the input channel
    always @(posedge i_clk) begin : drive_samples
        t_flow_sample nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                nxt.flow   = in_if.flow_sample;
                nxt.t_ms   = in_if.sample_time_ms;
                nxt.resync = in_if.resync;
                integrate_sample(nxt);
                n_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    nxt = sample_backlog.pop_front();
                    in_if.flow_sample    <= nxt.flow;
                    in_if.sample_time_ms <= nxt.t_ms;
                    in_if.resync         <= nxt.resync;
                    in_if.valid          <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // check each result transaction
    always @(posedge i_clk) begin : check_reports
        t_phase_report want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid === 1'b1 && out_if.ready) begin
                if (phase_reports.size() == 0) begin
                    flag_mismatch("result with no sample outstanding");
                end else begin
                    want = phase_reports.pop_front();
                    if (out_if.flow_echo !== want.flow)
                        flag_mismatch($sformatf("flow_echo %0d, want %0d",
                                                out_if.flow_echo, want.flow));
                    if (out_if.phase_event !== want.ev)
                        flag_mismatch($sformatf("phase_event %0d, want %0d",
                                                out_if.phase_event, want.ev));
                    if (out_if.phase_volume !== want.vol)
                        flag_mismatch($sformatf("phase_volume %0d, want %0d",
                                                out_if.phase_volume, want.vol));
                    if (out_if.breath_rate !== want.rate)
                        flag_mismatch($sformatf("breath_rate %0d, want %0d",
                                                out_if.breath_rate, want.rate));
                end
                n_results++;
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_sample(input int flow, input logic [TIME_W-1:0] t_ms,
                                input logic resync);
        t_flow_sample s;
        s.flow   = FLOW_WIDTH'(flow);
        s.t_ms   = t_ms;
        s.resync = resync;
        sample_backlog.push_back(s);
        n_queued++;
    endtask

    function automatic int pick_flow(input bit insp, input int thr);
        case ($urandom_range(0, 9))
            0:       return insp ? thr : thr - 1;
            1:       return insp ? FLOW_MAX : FLOW_MIN;
            default: return insp ? thr + int'($urandom_range(0, FLOW_MAX - thr))
                                 : int'($urandom_range(0, FLOW_MAX + thr)) + FLOW_MIN;
        endcase
    endfunction

    // alternating breath phases with random content, some noise mixed in
    task automatic queue_breaths(input int n_items, input int thr);
        int                made;
        int                run_len;
        int                r;
        bit                insp;
        logic [TIME_W-1:0] t_ms;
        made = 0;
        insp = $urandom_range(0, 1);
        t_ms = $urandom;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_sample(int'($urandom), $urandom, $urandom_range(0, 1));
                made++;
            end else begin
                run_len = $urandom_range(1, 6);
                for (int k = 0; k < run_len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 2) begin
                        t_ms = t_ms + $urandom;
                    end else if (r < 7) begin
                        t_ms = t_ms + $urandom_range(0, 1 << 20);
                    end else begin
                        t_ms = t_ms + $urandom_range(0, 40);
                    end
                    queue_sample(pick_flow(insp, thr), t_ms, $urandom_range(0, 149) == 0);
                    made++;
                end
                insp = !insp;
            end
        end
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_THRESHOLD, 2'b00};
        pwdata  <= {22'($urandom), thr};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        thr_cfg = thr;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || phase_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int thr;
        in_if.valid          = 1'b0;
        in_if.flow_sample    = '0;
        in_if.sample_time_ms = '0;
        in_if.resync         = 1'b0;
        out_if.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_rst_n              = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // setup wait, then threshold edges, zero and wrapped intervals, saturation
        queue_sample(-100, 32'd10, 1'b0);
        queue_sample(500, 32'd20, 1'b0);
        queue_sample(FLOW_MAX, 32'd30, 1'b0);
        queue_sample(32, 32'd40, 1'b0);
        queue_sample(31, 32'd45, 1'b0);
        queue_sample(FLOW_MIN, 32'd50, 1'b0);
        queue_sample(40, 32'd50, 1'b0);
        queue_sample(-1, 32'd50, 1'b0);
        queue_sample(100, 32'd60, 1'b0);
        queue_sample(-5, 32'd50, 1'b0);
        queue_sample(FLOW_MAX, 32'hFFFF_FFF0, 1'b0);
        queue_sample(FLOW_MAX, 32'h0000_0010, 1'b0);
        queue_sample(FLOW_MIN, 32'h0000_0020, 1'b0);
        queue_sample(FLOW_MIN, 32'hFFFF_0000, 1'b0);
        queue_sample(1000, 32'hFFFF_0010, 1'b0);
        queue_sample(31, 32'h7FFF_0000, 1'b0);
        queue_sample(500, 32'h7FFF_0001, 1'b0);
        queue_sample(500, 32'd100, 1'b1);
        queue_sample(-200, 32'd110, 1'b0);
        queue_sample(200, 32'd120, 1'b0);
        queue_sample(0, 32'd130, 1'b0);
        queue_sample(300, 32'd140, 1'b1);
        queue_sample(-300, 32'd150, 1'b0);
        queue_sample(300, 32'd160, 1'b0);
        queue_sample(300, 32'd170, 1'b0);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       thr = 0;
                1:       thr = (1 << THR_W) - 1;
                4:       thr = int'(THR_RESET);
                default: thr = $urandom_range(0, (1 << THR_W) - 1);
            endcase
            write_threshold(THR_W'(thr));
            if (p < 2) begin
                send_gap_pct   = 21;
                recv_stall_pct = 48;
            end else if (p < 4) begin
                send_gap_pct   = 48;
                recv_stall_pct = 21;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            queue_breaths(ITEMS_PER_PHASE, thr);
            wait_idle();
        end

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
